// ===== design/c8ic_pkg.sv =====
package c8ic_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int ADDR_W    = 12;
    localparam int ROWS      = 32;
    localparam int COLS      = 64;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 120;

    localparam logic [11:0] START_PC = 12'h200;
    localparam logic [15:0] CLS_WORD = 16'h00E0;
    localparam logic [15:0] RET_WORD = 16'h00EE;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_EXEC = 2'd1;
    localparam logic [1:0] OP_ROW  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [3:0] FAM_SYS  = 4'h0;
    localparam logic [3:0] FAM_JP   = 4'h1;
    localparam logic [3:0] FAM_CALL = 4'h2;
    localparam logic [3:0] FAM_SEQ  = 4'h3;
    localparam logic [3:0] FAM_SNE  = 4'h4;
    localparam logic [3:0] FAM_SEQR = 4'h5;
    localparam logic [3:0] FAM_LD   = 4'h6;
    localparam logic [3:0] FAM_ADD  = 4'h7;
    localparam logic [3:0] FAM_SNER = 4'h9;
    localparam logic [3:0] FAM_LDI  = 4'hA;
    localparam logic [3:0] FAM_DRW  = 4'hD;

    localparam logic [3:0] FLAG_IDX = 4'hF;

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_FET0  = 14'b00000000000100,
        S_FET1  = 14'b00000000001000,
        S_FET2  = 14'b00000000010000,
        S_RDX   = 14'b00000000100000,
        S_RDY   = 14'b00000001000000,
        S_EXEC  = 14'b00000010000000,
        S_RET   = 14'b00000100000000,
        S_DRD   = 14'b00001000000000,
        S_DWR   = 14'b00010000000000,
        S_DVF   = 14'b00100000000000,
        S_ROW   = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    typedef struct packed {
        logic [63:0] row;
        logic        coll;
    } t_pix_res;

endpackage

// ===== design/c8ic_pix.sv =====
module c8ic_pix (
    input  logic [7:0]      i_sprite,
    input  logic [5:0]      i_x0,
    input  logic [63:0]     i_row,
    output c8ic_pkg::t_pix_res o_res
);

    logic [63:0] base;
    logic [63:0] mask;
    logic [6:0]  lsh;

    // place sprite at the left edge, then rotate right by x0 so pixels wrap
    assign base = {i_sprite, 56'd0};
    assign lsh  = 7'd64 - {1'b0, i_x0};
    assign mask = (base >> i_x0) | (base << lsh);

    assign o_res.row  = i_row ^ mask;
    assign o_res.coll = |(i_row & mask);

endmodule

// ===== design/chip8_instruction_core_unit.sv =====
// CHIP-8 instruction core.
// Input stream (s_axis): one transfer is one command: load a memory byte,
// execute one instruction at PC, or read one framebuffer row. Output stream
// (m_axis): exactly one result transfer per command, carrying PC, I, VF,
// the row (read only), the executed word (execute only) and a status code.
// Commands are handled one at a time by a small sequencer around one
// registered memory read port, a shared 12-bit address adder and a sprite
// rotate/XOR unit. A load or an unknown opcode goes straight to the done
// state; a row read passes through the row state; an instruction is
// fetched, reads its registers and executes; a return from a nonempty
// stack then loads PC from the stack, and a draw runs, per sprite row,
// a memory and framebuffer read, then a framebuffer write. The input
// side is ready again right after the result is loaded into the output
// register, so a stalled receiver holds only one result; a further
// finished result waits in the core. After reset the core clears its
// 4096-byte memory one byte per cycle and accepts no command meanwhile;
// registers, stack level and the framebuffer clear at once.
module chip8_instruction_core_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // opcode[1:0], load_address[13:2], load_byte[21:14], row_select[26:22], zero pad
    input  logic [31:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // pc_now[11:0], index_now[23:12], flag_reg[31:24], row_bits[95:32],
    // fetched_word[111:96], status[113:112], zero pad
    output logic [119:0] o_m_axis_tdata
);

    localparam int SP_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);

    c8ic_pkg::t_state r_state, n_state;

    logic [7:0]  r_mem [c8ic_pkg::MEM_BYTES];
    logic [7:0]  r_mem_q;
    logic [63:0] r_fb [c8ic_pkg::ROWS];
    logic [63:0] r_fb_q;
    logic        r_fb_qv;
    logic [31:0] r_fb_vld;
    logic [11:0] r_stk [STACK_DEPTH];
    logic [11:0] r_stk_q;
    logic [7:0]  r_v [16];

    logic [11:0] r_pc, r_idx, r_clr;
    logic [LVL_W-1:0] r_lvl;
    logic [7:0]  r_hi, r_a, r_b;
    logic [15:0] r_word;
    logic [63:0] r_row;
    logic [1:0]  r_status;
    logic [3:0]  r_cnt;
    logic        r_coll;
    logic        r_ov;
    logic [119:0] r_out;

    logic [11:0] mem_raddr, add_base, add_off;
    logic        mem_we;
    logic [11:0] mem_waddr;
    logic [7:0]  mem_wdata;
    logic [4:0]  fb_addr;
    logic [SP_W-1:0] stk_raddr;
    logic [3:0]  v_raddr;
    logic [7:0]  v_rdata;
    logic [7:0]  cmp_opnd;
    logic        cmp_eq;
    logic        skip;
    logic [3:0]  fam, rx, ry, nrows;
    c8ic_pkg::t_pix_res pix;
    logic        accept;

    logic [1:0]  in_op;
    logic [11:0] in_addr;
    logic [7:0]  in_byte;
    logic [4:0]  in_rowsel;

    assign in_op     = i_s_axis_tdata[1:0];
    assign in_addr   = i_s_axis_tdata[13:2];
    assign in_byte   = i_s_axis_tdata[21:14];
    assign in_rowsel = i_s_axis_tdata[26:22];

    assign o_s_axis_tready = (r_state == c8ic_pkg::S_IDLE);
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    assign fam   = r_word[15:12];
    assign rx    = r_word[11:8];
    assign ry    = r_word[7:4];
    assign nrows = r_word[3:0];

    // shared address adder
    always_comb begin
        add_base = r_pc;
        add_off  = 12'd0;
        case (r_state)
            c8ic_pkg::S_FET1: add_off = 12'd1;
            c8ic_pkg::S_DRD: begin
                add_base = r_idx;
                add_off  = {8'd0, r_cnt};
            end
            default: add_off = 12'd0;
        endcase
        mem_raddr = add_base + add_off;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = 8'd0;
        if (r_state == c8ic_pkg::S_CLEAR) begin
            mem_we = 1'b1;
        end else if (accept && in_op == c8ic_pkg::OP_LOAD) begin
            mem_we    = 1'b1;
            mem_waddr = in_addr;
            mem_wdata = in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[mem_raddr];
    end

    assign fb_addr = (r_state == c8ic_pkg::S_IDLE) ? in_rowsel
                                                   : (r_b[4:0] + {1'b0, r_cnt});

    always_ff @(posedge i_clk) begin
        if (r_state == c8ic_pkg::S_DWR) begin
            r_fb[fb_addr] <= pix.row;
        end
        r_fb_q  <= r_fb[fb_addr];
        r_fb_qv <= r_fb_vld[fb_addr];
    end

    assign stk_raddr = SP_W'(r_lvl - LVL_W'(1));

    always_ff @(posedge i_clk) begin
        if (r_state == c8ic_pkg::S_EXEC && fam == c8ic_pkg::FAM_CALL && r_lvl != LVL_FULL) begin
            r_stk[r_lvl[SP_W-1:0]] <= r_pc;
        end
        r_stk_q <= r_stk[stk_raddr];
    end

    assign v_raddr  = (r_state == c8ic_pkg::S_RDX) ? rx : ry;
    assign v_rdata  = r_v[v_raddr];
    assign cmp_opnd = (fam == c8ic_pkg::FAM_SEQR || fam == c8ic_pkg::FAM_SNER)
                      ? r_b : r_word[7:0];
    assign cmp_eq   = (r_a == cmp_opnd);

    always_comb begin
        case (fam)
            c8ic_pkg::FAM_SEQ, c8ic_pkg::FAM_SEQR: skip = cmp_eq;
            c8ic_pkg::FAM_SNE, c8ic_pkg::FAM_SNER: skip = !cmp_eq;
            default:                               skip = 1'b0;
        endcase
    end

    c8ic_pix u_pix (
        .i_sprite (r_mem_q),
        .i_x0     (r_a[5:0]),
        .i_row    (r_fb_qv ? r_fb_q : 64'd0),
        .o_res    (pix)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            c8ic_pkg::S_CLEAR: if (r_clr == 12'hFFF) n_state = c8ic_pkg::S_IDLE;
            c8ic_pkg::S_IDLE: begin
                if (accept) begin
                    case (in_op)
                        c8ic_pkg::OP_EXEC: n_state = c8ic_pkg::S_FET0;
                        c8ic_pkg::OP_ROW:  n_state = c8ic_pkg::S_ROW;
                        default:           n_state = c8ic_pkg::S_DONE;
                    endcase
                end
            end
            c8ic_pkg::S_FET0: n_state = c8ic_pkg::S_FET1;
            c8ic_pkg::S_FET1: n_state = c8ic_pkg::S_FET2;
            c8ic_pkg::S_FET2: n_state = c8ic_pkg::S_RDX;
            c8ic_pkg::S_RDX:  n_state = c8ic_pkg::S_RDY;
            c8ic_pkg::S_RDY:  n_state = c8ic_pkg::S_EXEC;
            c8ic_pkg::S_EXEC: begin
                if (r_word == c8ic_pkg::RET_WORD && r_lvl != '0) begin
                    n_state = c8ic_pkg::S_RET;
                end else if (fam == c8ic_pkg::FAM_DRW) begin
                    n_state = (nrows == 4'd0) ? c8ic_pkg::S_DVF : c8ic_pkg::S_DRD;
                end else begin
                    n_state = c8ic_pkg::S_DONE;
                end
            end
            c8ic_pkg::S_RET:  n_state = c8ic_pkg::S_DONE;
            c8ic_pkg::S_DRD:  n_state = c8ic_pkg::S_DWR;
            c8ic_pkg::S_DWR:  n_state = (r_cnt == nrows - 4'd1) ? c8ic_pkg::S_DVF
                                                                : c8ic_pkg::S_DRD;
            c8ic_pkg::S_DVF:  n_state = c8ic_pkg::S_DONE;
            c8ic_pkg::S_ROW:  n_state = c8ic_pkg::S_DONE;
            c8ic_pkg::S_DONE: if (!r_ov || i_m_axis_tready) n_state = c8ic_pkg::S_IDLE;
            default:          n_state = c8ic_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= c8ic_pkg::S_CLEAR;
            r_clr    <= 12'd0;
            r_pc     <= c8ic_pkg::START_PC;
            r_idx    <= 12'd0;
            r_lvl    <= '0;
            r_fb_vld <= 32'd0;
            r_ov     <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                r_v[i] <= 8'd0;
            end
        end else begin
            r_state <= n_state;
            // hold a new result, or drop the one just taken
            if (r_state == c8ic_pkg::S_DONE && (!r_ov || i_m_axis_tready)) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                c8ic_pkg::S_CLEAR: r_clr <= r_clr + 12'd1;
                c8ic_pkg::S_IDLE: begin
                    r_row    <= 64'd0;
                    r_word   <= 16'd0;
                    r_status <= c8ic_pkg::ST_OK;
                end
                c8ic_pkg::S_FET1: r_hi <= r_mem_q;
                c8ic_pkg::S_FET2: begin
                    r_word <= {r_hi, r_mem_q};
                    r_pc   <= r_pc + 12'd2;
                end
                c8ic_pkg::S_RDX: r_a <= v_rdata;
                c8ic_pkg::S_RDY: r_b <= v_rdata;
                c8ic_pkg::S_EXEC: begin
                    r_cnt  <= 4'd0;
                    r_coll <= 1'b0;
                    if (skip) begin
                        r_pc <= r_pc + 12'd2;
                    end
                    case (fam)
                        c8ic_pkg::FAM_SYS: begin
                            if (r_word == c8ic_pkg::CLS_WORD) begin
                                r_fb_vld <= 32'd0;
                            end else if (r_word == c8ic_pkg::RET_WORD) begin
                                if (r_lvl == '0) begin
                                    r_status <= c8ic_pkg::ST_EMPTY;
                                end else begin
                                    r_lvl <= r_lvl - LVL_W'(1);
                                end
                            end
                        end
                        c8ic_pkg::FAM_JP: r_pc <= r_word[11:0];
                        c8ic_pkg::FAM_CALL: begin
                            if (r_lvl == LVL_FULL) begin
                                r_status <= c8ic_pkg::ST_FULL;
                            end else begin
                                r_lvl <= r_lvl + LVL_W'(1);
                                r_pc  <= r_word[11:0];
                            end
                        end
                        c8ic_pkg::FAM_LD:  r_v[rx] <= r_word[7:0];
                        c8ic_pkg::FAM_ADD: r_v[rx] <= r_a + r_word[7:0];
                        c8ic_pkg::FAM_LDI: r_idx <= r_word[11:0];
                        default: ;
                    endcase
                end
                c8ic_pkg::S_RET: r_pc <= r_stk_q;
                c8ic_pkg::S_DWR: begin
                    r_fb_vld[fb_addr] <= 1'b1;
                    r_coll <= r_coll | pix.coll;
                    r_cnt  <= r_cnt + 4'd1;
                end
                c8ic_pkg::S_DVF: r_v[c8ic_pkg::FLAG_IDX] <= {7'd0, r_coll};
                c8ic_pkg::S_ROW: r_row <= r_fb_qv ? r_fb_q : 64'd0;
                default: ;
            endcase
        end
    end

    // load the result register on the way out of the done state
    always_ff @(posedge i_clk) begin
        if (r_state == c8ic_pkg::S_DONE && (!r_ov || i_m_axis_tready)) begin
            r_out <= {6'd0, r_status, r_word, r_row, r_v[c8ic_pkg::FLAG_IDX], r_idx, r_pc};
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_out;

endmodule

// ===== design/c8ic_checker.sv =====
module c8ic_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [119:0] o_m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // one command at a time: busy right after a transfer in
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("ready right after an accepted command");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[113:112] != 2'd3)
        else $error("undefined status code");

    // a row read carries no instruction word
    a_row_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[95:32] != 64'd0 |-> o_m_axis_tdata[111:96] == 16'd0)
        else $error("row and instruction word in one result");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[119:114] == 6'd0)
        else $error("pad bits set");

endmodule

bind chip8_instruction_core_unit c8ic_checker u_c8ic_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
